/* rtl/srtp_pkg.sv */
// Shared constants and types for the slip-ratio traction PID block.
`timescale 1ns / 1ps
package srtp_pkg;

    localparam int SPEED_BITS = 10;

    localparam int MAG_W      = 15;
    localparam int SLIP_W     = 16;
    localparam int ERR_W      = 18;
    localparam int DERR_W     = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int WIN_W      = 15;
    localparam int DT_W       = 16;
    localparam int DRIVE_W    = 16;

    localparam int MUL_A_W    = GAIN_W + 1;
    localparam int MUL_B_W    = 21;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int INTEG_W    = 40;
    localparam int INTEG_LO_W = 20;
    localparam int INTEG_HI_W = INTEG_W - INTEG_LO_W;
    localparam int ISUM_W     = 57;
    localparam int SUM_W      = 42;

    localparam int DIVR_W     = 16;
    localparam int DIVN_W     = 33;
    localparam int STEP_W     = $clog2(DIVN_W + 1);
    localparam int SLIP_STEPS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd6;

    typedef struct packed {
        logic              start;
        logic [DIVR_W-1:0] divisor;
        logic [DIVR_W-1:0] rem_init;
        logic [DIVN_W-1:0] dividend;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/srtp_mul.sv */
// Shared registered signed multiplier used by the PID sequencer.
`timescale 1ns / 1ps
module srtp_mul (
    input  logic                                    aclk,
    input  logic signed [srtp_pkg::MUL_A_W-1:0]     op_a,
    input  logic signed [srtp_pkg::MUL_B_W-1:0]     op_b,
    output logic signed [srtp_pkg::PROD_W-1:0]      product
);

    logic signed [srtp_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

/* rtl/srtp_divider.sv */
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module srtp_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srtp_pkg::div_req_t   req,
    output srtp_pkg::div_rsp_t   rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [srtp_pkg::STEP_W-1:0]   steps_reg;
    logic [srtp_pkg::DIVR_W-1:0]   rem_reg;
    logic [srtp_pkg::DIVR_W-1:0]   divisor_reg;
    logic [srtp_pkg::DIVN_W-1:0]   num_reg;
    logic [srtp_pkg::DIVN_W-1:0]   quo_reg;

    logic [srtp_pkg::DIVR_W:0]     trial;
    logic [srtp_pkg::DIVR_W:0]     trial_diff;
    logic                          fits;
    logic [srtp_pkg::DIVR_W-1:0]   rem_next;

    assign trial      = {rem_reg, num_reg[srtp_pkg::DIVN_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign rem_next   = fits ? trial_diff[srtp_pkg::DIVR_W-1:0]
                             : trial[srtp_pkg::DIVR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg    <= 1'b1;
                steps_reg   <= req.steps;
                rem_reg     <= req.rem_init;
                divisor_reg <= req.divisor;
                num_reg     <= req.dividend;
                quo_reg     <= '0;
            end else if (busy_reg) begin
                rem_reg   <= rem_next;
                num_reg   <= {num_reg[srtp_pkg::DIVN_W-2:0], 1'b0};
                quo_reg   <= {quo_reg[srtp_pkg::DIVN_W-2:0], fits};
                steps_reg <= steps_reg - 1'b1;
                if (steps_reg == srtp_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/slip_ratio_traction_pid_unit.sv */
// Top level of the slip-ratio PID traction controller with its step sequencer.
// The slip divide is skipped when both speeds are zero, and the derivative divide runs
// only with active correction and nonzero elapsed_us.
// Throughput: one word at a time; s_ready returns the cycle after the result word is taken.
// The shared one-bit-per-cycle divider runs 16 steps for slip, 33 for the derivative.
// Synchronous active-low reset loads config defaults, clears integrator and last error.
`timescale 1ns / 1ps
module slip_ratio_traction_pid_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [srtp_pkg::SPEED_BITS-1:0]        s_front_speed,
    input  logic [srtp_pkg::SPEED_BITS-1:0]        s_rear_speed,
    input  logic [srtp_pkg::DT_W-1:0]              s_elapsed_us,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [srtp_pkg::DRIVE_W-1:0]    m_drive_command,
    output logic signed [srtp_pkg::SLIP_W-1:0]     m_slip_ratio,
    output logic                                   m_correction_active,
    output logic                                   m_braking,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [srtp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [srtp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_ERR, S_MUL_INT, S_ACC_INT, S_MUL_ILO,
        S_MUL_IHI, S_ISUM, S_DMUL, S_DIV2, S_OUT
    } state_t;

    state_t state_reg;

    logic [srtp_pkg::GAIN_W-1:0]   gain_p_reg, gain_i_reg, gain_d_reg, period_reg;
    logic [srtp_pkg::WIN_W-1:0]    slip_low_reg, slip_high_reg, deadband_reg;

    logic                          brake_reg;
    logic                          active_reg;
    logic                          dneg_reg;
    logic                          out_valid_reg;
    logic [srtp_pkg::DT_W-1:0]     dt_reg;
    logic [srtp_pkg::MAG_W:0]      mag_reg;
    logic signed [srtp_pkg::SLIP_W-1:0]  slip_reg;
    logic signed [srtp_pkg::ERR_W-1:0]   err_reg;
    logic signed [srtp_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [srtp_pkg::INTEG_W-1:0] integ_reg;
    logic signed [srtp_pkg::PROD_W-1:0]  ilo_reg;
    logic signed [srtp_pkg::ISUM_W-1:0]  isum_reg;
    logic signed [srtp_pkg::SUM_W-1:0]   pd_reg;
    logic signed [srtp_pkg::SUM_W-1:0]   sum_reg;
    logic signed [srtp_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [srtp_pkg::SLIP_W-1:0]  slip_out_reg;
    logic                          active_out_reg;
    logic                          brake_out_reg;

    srtp_pkg::div_req_t            div_req;
    srtp_pkg::div_rsp_t            div_rsp;
    logic signed [srtp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [srtp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [srtp_pkg::PROD_W-1:0]  prod;

    logic                              accept;
    logic                              brake_in;
    logic [srtp_pkg::SPEED_BITS-1:0]   big_in;
    logic [srtp_pkg::SPEED_BITS-1:0]   diff_in;

    logic [srtp_pkg::MAG_W:0]          target_sum;
    logic [srtp_pkg::ERR_W-1:0]        target_ext;
    logic [srtp_pkg::ERR_W-1:0]        mag_ext;
    logic signed [srtp_pkg::ERR_W-1:0] err_raw;
    logic signed [srtp_pkg::ERR_W-1:0] err_abs;
    logic signed [srtp_pkg::ERR_W-1:0] err_next;
    logic                              active_next;
    logic signed [srtp_pkg::SLIP_W-1:0] slip_next;
    logic [srtp_pkg::MAG_W:0]          mag_sat;

    logic signed [srtp_pkg::DERR_W-1:0]  derr;
    logic signed [srtp_pkg::INTEG_W:0]   integ_sum;
    logic signed [srtp_pkg::INTEG_W-1:0] integ_next;
    logic signed [srtp_pkg::PROD_W-1:0]  prod_abs;
    logic signed [srtp_pkg::SUM_W-1:0]   dterm;
    logic signed [srtp_pkg::DRIVE_W-1:0] drive_next;

    assign accept   = s_valid && s_ready;
    assign brake_in = s_front_speed > s_rear_speed;
    assign big_in   = brake_in ? s_front_speed : s_rear_speed;
    assign diff_in  = brake_in ? (s_front_speed - s_rear_speed)
                               : (s_rear_speed - s_front_speed);

    assign mag_sat = (!brake_reg && (div_rsp.quotient > srtp_pkg::DIVN_W'(32767)))
                     ? {1'b0, {srtp_pkg::MAG_W{1'b1}}}
                     : div_rsp.quotient[srtp_pkg::MAG_W:0];

    assign target_sum  = {1'b0, slip_low_reg} + {1'b0, slip_high_reg};
    assign target_ext  = {3'b000, target_sum[srtp_pkg::MAG_W:1]};
    assign mag_ext     = {2'b00, mag_reg};
    assign err_raw     = brake_reg ? $signed(mag_ext - target_ext)
                                   : $signed(target_ext - mag_ext);
    assign err_abs     = err_raw[srtp_pkg::ERR_W-1] ? -err_raw : err_raw;
    assign err_next    = (err_abs < $signed({3'b000, deadband_reg})) ? '0 : err_raw;
    assign active_next = (mag_reg < {1'b0, slip_low_reg}) || (mag_reg > {1'b0, slip_high_reg});
    assign slip_next   = brake_reg ? -$signed(mag_reg) : $signed(mag_reg);

    assign derr = {err_reg[srtp_pkg::ERR_W-1], err_reg}
                - {prev_err_reg[srtp_pkg::ERR_W-1], prev_err_reg};

    assign integ_sum = {integ_reg[srtp_pkg::INTEG_W-1], integ_reg}
                     + {{(srtp_pkg::INTEG_W + 1 - srtp_pkg::PROD_W){prod[srtp_pkg::PROD_W-1]}},
                        prod};
    always_comb begin
        if (integ_sum[srtp_pkg::INTEG_W] != integ_sum[srtp_pkg::INTEG_W-1]) begin
            integ_next = integ_sum[srtp_pkg::INTEG_W]
                ? {1'b1, {(srtp_pkg::INTEG_W-1){1'b0}}}
                : {1'b0, {(srtp_pkg::INTEG_W-1){1'b1}}};
        end else begin
            integ_next = integ_sum[srtp_pkg::INTEG_W-1:0];
        end
    end

    assign prod_abs = prod[srtp_pkg::PROD_W-1] ? -prod : prod;
    assign dterm    = dneg_reg
        ? -$signed({{(srtp_pkg::SUM_W - srtp_pkg::DIVN_W){1'b0}}, div_rsp.quotient})
        :  $signed({{(srtp_pkg::SUM_W - srtp_pkg::DIVN_W){1'b0}}, div_rsp.quotient});

    always_comb begin
        if (sum_reg[srtp_pkg::SUM_W-1:30] == {(srtp_pkg::SUM_W - 30){sum_reg[30]}}) begin
            drive_next = sum_reg[30:15];
        end else if (sum_reg[srtp_pkg::SUM_W-1]) begin
            drive_next = {1'b1, {(srtp_pkg::DRIVE_W-1){1'b0}}};
        end else begin
            drive_next = {1'b0, {(srtp_pkg::DRIVE_W-1){1'b1}}};
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_INT: begin
                mul_a = {1'b0, period_reg};
                mul_b = srtp_pkg::MUL_B_W'(err_reg);
            end
            S_ACC_INT: begin
                mul_a = {1'b0, gain_p_reg};
                mul_b = srtp_pkg::MUL_B_W'(err_reg);
            end
            S_MUL_ILO: begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = {1'b0, integ_reg[srtp_pkg::INTEG_LO_W-1:0]};
            end
            S_MUL_IHI: begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = {integ_reg[srtp_pkg::INTEG_W-1],
                         integ_reg[srtp_pkg::INTEG_W-1:srtp_pkg::INTEG_LO_W]};
            end
            S_ISUM: begin
                mul_a = {1'b0, gain_d_reg};
                mul_b = srtp_pkg::MUL_B_W'(derr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req          = '0;
        div_req.divisor  = srtp_pkg::DIVR_W'(big_in);
        div_req.rem_init = srtp_pkg::DIVR_W'(diff_in >> 1);
        div_req.dividend = {diff_in[0], {(srtp_pkg::DIVN_W-1){1'b0}}};
        div_req.steps    = srtp_pkg::STEP_W'(srtp_pkg::SLIP_STEPS);
        if (state_reg == S_IDLE) begin
            div_req.start = accept && (big_in != '0);
        end else if (state_reg == S_DMUL) begin
            div_req.start    = active_reg && (dt_reg != '0);
            div_req.divisor  = dt_reg;
            div_req.rem_init = '0;
            div_req.dividend = prod_abs[srtp_pkg::DIVN_W-1:0];
            div_req.steps    = srtp_pkg::STEP_W'(srtp_pkg::DIVN_W);
        end
    end

    srtp_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    srtp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= 16'd1280;
            gain_i_reg    <= 16'd25600;
            gain_d_reg    <= 16'd0;
            slip_low_reg  <= 15'd3277;
            slip_high_reg <= 15'd16384;
            deadband_reg  <= 15'd328;
            period_reg    <= 16'd918;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    srtp_pkg::CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                    srtp_pkg::CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                    srtp_pkg::CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                    srtp_pkg::CFG_SLIP_LOW:  slip_low_reg  <= cfg_data[srtp_pkg::WIN_W-1:0];
                    srtp_pkg::CFG_SLIP_HIGH: slip_high_reg <= cfg_data[srtp_pkg::WIN_W-1:0];
                    srtp_pkg::CFG_DEADBAND:  deadband_reg  <= cfg_data[srtp_pkg::WIN_W-1:0];
                    srtp_pkg::CFG_PERIOD:    period_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        brake_reg <= brake_in;
                        dt_reg    <= s_elapsed_us;
                        mag_reg   <= '0;
                        state_reg <= (big_in != '0) ? S_DIV1 : S_ERR;
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        mag_reg   <= mag_sat;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    err_reg    <= err_next;
                    active_reg <= active_next;
                    slip_reg   <= slip_next;
                    state_reg  <= S_MUL_INT;
                end
                S_MUL_INT: begin
                    state_reg <= S_ACC_INT;
                end
                S_ACC_INT: begin
                    integ_reg <= integ_next;
                    state_reg <= S_MUL_ILO;
                end
                S_MUL_ILO: begin
                    pd_reg <= active_reg
                        ? {{(srtp_pkg::SUM_W - srtp_pkg::PROD_W){prod[srtp_pkg::PROD_W-1]}}, prod}
                        : '0;
                    state_reg <= S_MUL_IHI;
                end
                S_MUL_IHI: begin
                    ilo_reg   <= prod;
                    state_reg <= S_ISUM;
                end
                S_ISUM: begin
                    isum_reg <= {{(srtp_pkg::ISUM_W - srtp_pkg::PROD_W){ilo_reg[srtp_pkg::PROD_W-1]}},
                                 ilo_reg}
                              + {prod[srtp_pkg::ISUM_W-srtp_pkg::INTEG_LO_W-1:0],
                                 {srtp_pkg::INTEG_LO_W{1'b0}}};
                    state_reg <= S_DMUL;
                end
                S_DMUL: begin
                    sum_reg   <= {isum_reg[srtp_pkg::ISUM_W-1], isum_reg[srtp_pkg::ISUM_W-1:16]}
                               + pd_reg;
                    dneg_reg  <= prod[srtp_pkg::PROD_W-1];
                    state_reg <= (active_reg && (dt_reg != '0)) ? S_DIV2 : S_OUT;
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        sum_reg   <= sum_reg + dterm;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    drive_reg      <= drive_next;
                    slip_out_reg   <= slip_reg;
                    active_out_reg <= active_reg;
                    brake_out_reg  <= brake_reg;
                    prev_err_reg   <= err_reg;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready             = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready           = 1'b1;
    assign m_valid             = out_valid_reg;
    assign m_drive_command     = drive_reg;
    assign m_slip_ratio        = slip_out_reg;
    assign m_correction_active = active_out_reg;
    assign m_braking           = brake_out_reg;

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("Divider finished outside a divide state.");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("Result word raised outside the output state.");

    a_deriv_div_cond: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV2) |-> (active_reg && dt_reg != '0))
        else $error("Derivative divide entered without an active nonzero period.");

endmodule
